FILE: hw/rtl/sfp_pkg.sv
// Shared types and constants for the serial frame parser.
// Used by the controller, the datapath, the top level and the checker.
package sfp_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 4;
   localparam int CSR_IDX_W  = 8;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_START  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACK    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NAK    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CANCEL = 8'd3;

   localparam logic [7:0] START_RST  = 8'h01;
   localparam logic [7:0] ACK_RST    = 8'h06;
   localparam logic [7:0] NAK_RST    = 8'h15;
   localparam logic [7:0] CANCEL_RST = 8'h18;

   localparam logic [7:0] CHECK_SEED   = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd3;

   typedef enum logic [2:0] {
      EV_ACK     = 3'd0,
      EV_NAK     = 3'd1,
      EV_CANCEL  = 3'd2,
      EV_GOOD    = 3'd3,
      EV_STRAY   = 3'd4,
      EV_BAD_LEN = 3'd5,
      EV_CSUM    = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEN,
      S_TYPE,
      S_CMD,
      S_DATA,
      S_CHECK,
      S_READ,
      S_SHOW
   } state_type;

   typedef struct packed {
      logic      load_len;
      logic      load_type;
      logic      load_cmd;
      logic      store_data;
      logic      rd_issue;
      logic      emit_item;
      logic      emit_event;
      event_type ev;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_ack;
      logic is_nak;
      logic is_cancel;
      logic len_bad;
      logic len_zero;
      logic data_done;
      logic check_ok;
      logic drain_last;
      logic slot_free;
   } stat_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0] frame_type;
      logic [7:0] command;
      logic [5:0] payload_len;
      logic [7:0] payload_byte;
      logic [4:0] payload_index;
      logic       has_payload;
      logic       last;
   } rsp_type;

endpackage

FILE: hw/rtl/sfp_ctrl.sv
// Frame parser controller: phase state machine, issues datapath commands.
// Depends on sfp_pkg.
module sfp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sfp_pkg::stat_type stat,
   output sfp_pkg::cmd_type  cmd
);
   import sfp_pkg::*;

   state_type state_ff, state_in;
   logic      rx_phase;
   logic      take;

   assign rx_phase   = !(state_ff == S_READ || state_ff == S_SHOW);
   assign req_tready = rx_phase && stat.slot_free;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.ev   = EV_ACK;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               // start code wins over the control codes
               if (stat.is_start) begin
                  state_in = S_LEN;
               end else begin
                  cmd.emit_event = 1'b1;
                  if (stat.is_ack)         cmd.ev = EV_ACK;
                  else if (stat.is_nak)    cmd.ev = EV_NAK;
                  else if (stat.is_cancel) cmd.ev = EV_CANCEL;
                  else                     cmd.ev = EV_STRAY;
               end
            end
         end
         S_LEN: begin
            if (take) begin
               if (stat.len_bad) begin
                  cmd.emit_event = 1'b1;
                  cmd.ev         = EV_BAD_LEN;
                  state_in       = S_IDLE;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = S_TYPE;
               end
            end
         end
         S_TYPE: begin
            if (take) begin
               cmd.load_type = 1'b1;
               state_in      = S_CMD;
            end
         end
         S_CMD: begin
            if (take) begin
               cmd.load_cmd = 1'b1;
               state_in     = stat.len_zero ? S_CHECK : S_DATA;
            end
         end
         S_DATA: begin
            if (take) begin
               cmd.store_data = 1'b1;
               if (stat.data_done) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (take) begin
               if (!stat.check_ok) begin
                  cmd.emit_event = 1'b1;
                  cmd.ev         = EV_CSUM;
                  state_in       = S_IDLE;
               end else if (stat.len_zero) begin
                  cmd.emit_event = 1'b1;
                  cmd.ev         = EV_GOOD;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_SHOW;
         end
         S_SHOW: begin
            if (stat.slot_free) begin
               cmd.emit_item = 1'b1;
               state_in      = stat.drain_last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/sfp_dp.sv
// Frame parser datapath: code registers, counters, checksum, payload buffer
// and the result register. Depends on sfp_pkg.
module sfp_dp #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [sfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_data,
   input  logic [sfp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  sfp_pkg::cmd_type                cmd,
   input  logic                            rsp_tready,
   output sfp_pkg::stat_type               stat,
   output logic                            rsp_valid,
   output sfp_pkg::rsp_type                rsp
);
   import sfp_pkg::*;

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 3);

   logic [7:0] start_ff, start_in;
   logic [7:0] ack_ff, ack_in;
   logic [7:0] nak_ff, nak_in;
   logic [7:0] cancel_ff, cancel_in;

   logic [CNT_W-1:0] exp_len_ff, exp_len_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]       check_ff, check_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       mem_q_ff;
   logic [7:0]       payload_mem [MAX_PAYLOAD];
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // csr decode
   always_comb begin
      start_in  = start_ff;
      ack_in    = ack_ff;
      nak_in    = nak_ff;
      cancel_in = cancel_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START:  start_in  = csr_data;
            REG_ACK:    ack_in    = csr_data;
            REG_NAK:    nak_in    = csr_data;
            REG_CANCEL: cancel_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      rd_idx_in  = rd_idx_ff;
      check_in   = check_ff;
      type_in    = type_ff;
      command_in = command_ff;
      if (cmd.load_len) begin
         exp_len_in = CNT_W'(req_tdata - LEN_OVERHEAD);
         seen_in    = '0;
         rd_idx_in  = '0;
         check_in   = CHECK_SEED ^ req_tdata;
      end
      if (cmd.load_type) begin
         type_in  = req_tdata;
         check_in = check_ff ^ req_tdata;
      end
      if (cmd.load_cmd) begin
         command_in = req_tdata;
         check_in   = check_ff ^ req_tdata;
      end
      if (cmd.store_data) begin
         seen_in  = seen_ff + CNT_W'(1);
         check_in = check_ff ^ req_tdata;
      end
      if (cmd.emit_item) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.emit_event) begin
         rsp_in       = '0;
         rsp_in.ev    = cmd.ev;
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         // empty good frame still carries type and command
         if (cmd.ev == EV_GOOD) begin
            rsp_in.frame_type = type_ff;
            rsp_in.command    = command_ff;
         end
      end else if (cmd.emit_item) begin
         rsp_in.ev            = EV_GOOD;
         rsp_in.frame_type    = type_ff;
         rsp_in.command       = command_ff;
         rsp_in.payload_len   = 6'(exp_len_ff);
         rsp_in.payload_byte  = mem_q_ff;
         rsp_in.payload_index = 5'(rd_idx_ff);
         rsp_in.has_payload   = 1'b1;
         rsp_in.last          = stat.drain_last;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RST;
         ack_ff       <= ACK_RST;
         nak_ff       <= NAK_RST;
         cancel_ff    <= CANCEL_RST;
         exp_len_ff   <= '0;
         seen_ff      <= '0;
         rd_idx_ff    <= '0;
         check_ff     <= CHECK_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         ack_ff       <= ack_in;
         nak_ff       <= nak_in;
         cancel_ff    <= cancel_in;
         exp_len_ff   <= exp_len_in;
         seen_ff      <= seen_in;
         rd_idx_ff    <= rd_idx_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      command_ff <= command_in;
      rsp_ff     <= rsp_in;
   end

   // payload buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_data) begin
         payload_mem[seen_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= payload_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      stat.is_start   = (req_tdata == start_ff);
      stat.is_ack     = (req_tdata == ack_ff);
      stat.is_nak     = (req_tdata == nak_ff);
      stat.is_cancel  = (req_tdata == cancel_ff);
      stat.len_bad    = (req_tdata < LEN_OVERHEAD) || (req_tdata > LEN_MAX);
      stat.len_zero   = (exp_len_ff == '0);
      stat.data_done  = (({1'b0, seen_ff} + (CNT_W+1)'(1)) == {1'b0, exp_len_ff});
      stat.check_ok   = (req_tdata == check_ff);
      stat.drain_last = (({1'b0, rd_idx_ff} + (CNT_W+1)'(1)) == {1'b0, exp_len_ff});
      stat.slot_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: hw/rtl/serial_frame_parser_xor_checksum_core.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata: rx_byte
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser, rsp_tlast
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// A received word is taken when req_tvalid and req_tready are both high. A control
// word, a bad length, a bad checksum or an empty frame gives one result in the
// next cycle. A good frame drains its payload from the buffer one result at a time:
// a buffer read, then a load of the output register. Reset is synchronous; the
// buffer needs no clearing. A stalled result holds rsp and, while pending,
// blocks further input; csr writes are always taken.
module serial_frame_parser_xor_checksum_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfp_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] frame_type, [15:8] command, [21:16] payload_len,
   // [29:22] payload_byte, [34:30] payload_index, [39:35] zero
   output logic [sfp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [sfp_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [2:0] event_res, [3] has_payload
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_data
);
   import sfp_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp;

   assign csr_ready = 1'b1;

   sfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfp_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.payload_index, rsp.payload_byte, rsp.payload_len,
                       rsp.command, rsp.frame_type};
   assign rsp_tuser = {rsp.has_payload, rsp.ev};
   assign rsp_tlast = rsp.last;

endmodule

FILE: hw/rtl/sfp_checker.sv
// Port-level checks for the frame parser core, bound to the top level.
// Depends on sfp_pkg.
module sfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sfp_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);
   import sfp_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                   && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // non-frame events are single words with cleared fields
   a_event_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != EV_GOOD
         |-> rsp_tlast && rsp_tdata == '0 && !rsp_tuser[3])
      else $error("event word carries frame fields");

   a_payload_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == EV_GOOD)
      else $error("payload flag on a non-frame event");

   // empty frame is reported as one word
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == EV_GOOD && !rsp_tuser[3] |-> rsp_tlast)
      else $error("empty frame word without tlast");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind serial_frame_parser_xor_checksum_core sfp_checker u_sfp_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for serial_frame_parser_xor_checksum_core: byte stream in, parse events out.
// Depends on sfp_pkg and the core RTL; keeps its own parser predictor.
module tb_top;
   import sfp_pkg::*;

   localparam int MAX_PAYLOAD = 32;
   localparam int DRAIN_SLACK = 8;     // cycles after the last expected word
   localparam int LONG_HOLD   = 300;   // receiver hold-off for the pressure test
   localparam int MAX_REPORTS = 40;
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 8'd4;   // no register behind it

   typedef enum logic [2:0] {
      WAIT_SOF,
      GET_LEN,
      GET_TYPE,
      GET_CMD,
      GET_DATA,
      GET_SUM
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   serial_frame_parser_xor_checksum_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser predictor state
   logic [7:0]      code_start, code_ack, code_nak, code_cancel;
   parse_phase_type ps_phase;
   logic [5:0]      ps_len;
   logic [5:0]      ps_seen;
   logic [7:0]      ps_csum;
   logic [7:0]      ps_type;
   logic [7:0]      ps_cmd;
   logic [7:0]      ps_buf [MAX_PAYLOAD];

   rsp_type expected_words [$];
   int      mismatches = 0;
   int      words_seen = 0;
   int      bytes_sent = 0;
   int      burst_left = 0;
   bit      steady_sender = 1'b0;
   logic    hold_tgl = 1'b0;

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_REPORTS)
         $display("[%0t] %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic reset_parser();
      code_start  = START_RST;
      code_ack    = ACK_RST;
      code_nak    = NAK_RST;
      code_cancel = CANCEL_RST;
      ps_phase    = WAIT_SOF;
      ps_len      = '0;
      ps_seen     = '0;
      ps_csum     = CHECK_SEED;
      ps_type     = '0;
      ps_cmd      = '0;
   endtask

   task automatic back_to_sof();
      ps_phase = WAIT_SOF;
      ps_len   = '0;
      ps_seen  = '0;
      ps_csum  = CHECK_SEED;
   endtask

   task automatic expect_event(input event_type ev);
      rsp_type w;
      w      = '0;
      w.ev   = ev;
      w.last = 1'b1;
      expected_words.push_back(w);
   endtask

   // advances the parser by one received byte and queues the words it causes
   task automatic parse_byte(input logic [7:0] b);
      rsp_type w;
      int      n;
      case (ps_phase)
         WAIT_SOF: begin
            if (b == code_start) ps_phase = GET_LEN;
            else if (b == code_ack) expect_event(EV_ACK);
            else if (b == code_nak) expect_event(EV_NAK);
            else if (b == code_cancel) expect_event(EV_CANCEL);
            else expect_event(EV_STRAY);
         end
         GET_LEN: begin
            if (b < LEN_OVERHEAD || int'(b) > MAX_PAYLOAD + int'(LEN_OVERHEAD)) begin
               back_to_sof();
               expect_event(EV_BAD_LEN);
            end else begin
               ps_len   = 6'(b - LEN_OVERHEAD);
               ps_seen  = '0;
               ps_csum  = CHECK_SEED ^ b;
               ps_phase = GET_TYPE;
            end
         end
         GET_TYPE: begin
            ps_type  = b;
            ps_csum ^= b;
            ps_phase = GET_CMD;
         end
         GET_CMD: begin
            ps_cmd   = b;
            ps_csum ^= b;
            ps_phase = (ps_len == 0) ? GET_SUM : GET_DATA;
         end
         GET_DATA: begin
            if (ps_seen < MAX_PAYLOAD) ps_buf[ps_seen] = b;
            ps_csum ^= b;
            ps_seen++;
            if (ps_seen >= ps_len) ps_phase = GET_SUM;
         end
         GET_SUM: begin
            n = ps_len;
            if (b != ps_csum) begin
               expect_event(EV_CSUM);
            end else if (n == 0) begin
               w            = '0;
               w.ev         = EV_GOOD;
               w.frame_type = ps_type;
               w.command    = ps_cmd;
               w.last       = 1'b1;
               expected_words.push_back(w);
            end else begin
               for (int k = 0; k < n; k++) begin
                  w.ev            = EV_GOOD;
                  w.frame_type    = ps_type;
                  w.command       = ps_cmd;
                  w.payload_len   = 6'(n);
                  w.payload_byte  = ps_buf[k];
                  w.payload_index = 5'(k);
                  w.has_payload   = 1'b1;
                  w.last          = (k == n - 1);
                  expected_words.push_back(w);
               end
            end
            back_to_sof();
         end
         default: back_to_sof();
      endcase
   endtask

   // one byte on req; valid stays up for the next call unless a gap is drawn
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      parse_byte(b);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_START:  code_start  = val;
         REG_ACK:    code_ack    = val;
         REG_NAK:    code_nak    = val;
         REG_CANCEL: code_cancel = val;
         default: ;
      endcase
   endtask

   task automatic program_codes(input logic [7:0] s, a, n, c);
      write_reg(REG_START, s);
      write_reg(REG_ACK, a);
      write_reg(REG_NAK, n);
      write_reg(REG_CANCEL, c);
      csr_valid <= 1'b0;
   endtask

   // fill < 0 gives random payload bytes
   task automatic send_frame(input logic [7:0] ftype, cmd, input int npay,
                             input bit bad_sum, input int fill);
      logic [7:0] len, sum, d;
      len = 8'(npay) + LEN_OVERHEAD;
      sum = CHECK_SEED ^ len ^ ftype ^ cmd;
      send_byte(code_start);
      send_byte(len);
      send_byte(ftype);
      send_byte(cmd);
      for (int i = 0; i < npay; i++) begin
         d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         sum ^= d;
         send_byte(d);
      end
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   // brings a half-received frame to an end so the parser is back at start-of-frame
   task automatic close_frame();
      while (ps_phase != WAIT_SOF) begin
         case (ps_phase)
            GET_LEN: send_byte(8'h00);
            GET_SUM: send_byte(ps_csum ^ 8'h01);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic send_bad_len();
      send_byte(code_start);
      send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                     : 8'($urandom_range(MAX_PAYLOAD + 4, 255)));
   endtask

   task automatic test_control_words();
      send_byte(code_ack);
      send_byte(code_nak);
      send_byte(code_cancel);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(code_start);
      send_byte(8'h00);
      send_byte(code_start);
      send_byte(8'd2);
      send_byte(code_start);
      send_byte(8'(MAX_PAYLOAD + 4));
      wait_drain();
   endtask

   task automatic test_frames();
      send_frame(8'hFF, 8'h00, 0, 1'b0, 0);     // empty payload
      send_frame(8'h00, 8'hFF, 1, 1'b1, 8'hFF); // bad checksum
      send_frame(8'hA5, 8'h5A, 2, 1'b0, 8'h00);
      wait_drain();
   endtask

   // start wins over ack, nak over cancel; a write to an unused index changes nothing
   task automatic test_code_priority();
      write_reg(REG_START, 8'h06);
      write_reg(REG_ACK, 8'h06);
      write_reg(REG_NAK, 8'hAA);
      write_reg(REG_CANCEL, 8'hAA);
      write_reg(REG_NONE, 8'h55);
      csr_valid <= 1'b0;
      send_byte(8'h06);
      send_byte(8'h00);
      send_byte(8'hAA);
      send_byte(8'h55);
      wait_drain();
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int first;
      int pick;
      int sz;
      bit max_done;
      first    = bytes_sent;
      max_done = 1'b0;
      while (bytes_sent - first < n_bytes) begin
         pick = $urandom_range(0, 19);
         sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                          : $urandom_range(0, 6);
         if (!max_done) begin
            send_frame(8'($urandom), 8'($urandom), MAX_PAYLOAD, 1'b0, -1);
            max_done = 1'b1;
         end else if (pick < 13) begin
            send_frame(8'($urandom), 8'($urandom), sz, 1'b0, -1);
         end else if (pick < 15) begin
            send_frame(8'($urandom), 8'($urandom), sz, 1'b1, -1);
         end else if (pick == 15) begin
            case ($urandom_range(0, 2))
               0: send_byte(code_ack);
               1: send_byte(code_nak);
               default: send_byte(code_cancel);
            endcase
         end else if (pick == 16) begin
            send_bad_len();
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      close_frame();
      wait_drain();
   endtask

   // receiver holds off while full frames keep coming, so req must stall
   task automatic test_backpressure();
      hold_tgl <= ~hold_tgl;
      for (int i = 0; i < 3; i++)
         send_frame(8'($urandom), 8'($urandom), MAX_PAYLOAD, 1'b0, -1);
      send_frame(8'($urandom), 8'($urandom), 0, 1'b0, -1);
      send_byte(code_ack);
      wait_drain();
   endtask

   // receiver: long hold on request, otherwise a stall pattern that changes mode
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   ready_mode = 0;
   logic [7:0] ready_tick = '0;
   always @(posedge clock) begin
      ready_tick <= ready_tick + 8'd1;
      if (ready_tick[5:0] == 0) ready_mode <= $urandom_range(0, 3);
      if (hold_tgl != hold_seen) begin
         hold_seen  <= hold_tgl;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (ready_tick[1:0] == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type got, want;
      string   bad;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.ev            = event_type'(rsp_tuser[2:0]);
         got.has_payload   = rsp_tuser[3];
         got.frame_type    = rsp_tdata[7:0];
         got.command       = rsp_tdata[15:8];
         got.payload_len   = rsp_tdata[21:16];
         got.payload_byte  = rsp_tdata[29:22];
         got.payload_index = rsp_tdata[34:30];
         got.last          = rsp_tlast;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word %0d: unexpected, got %h", words_seen, got));
         end else begin
            want = expected_words.pop_front();
            bad  = "";
            if (got.ev !== want.ev) bad = {bad, " event"};
            if (got.frame_type !== want.frame_type) bad = {bad, " type"};
            if (got.command !== want.command) bad = {bad, " command"};
            if (got.payload_len !== want.payload_len) bad = {bad, " len"};
            if (got.payload_byte !== want.payload_byte) bad = {bad, " byte"};
            if (got.payload_index !== want.payload_index) bad = {bad, " index"};
            if (got.has_payload !== want.has_payload) bad = {bad, " has_payload"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "")
               report_mismatch($sformatf("word %0d:%s differ, got %h want %h",
                                         words_seen, bad, got, want));
         end
         words_seen++;
      end
   end

   initial begin
      reset_parser();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_control_words();
      test_frames();
      test_random_traffic(70);
      test_code_priority();
      program_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
      test_random_traffic(70);
      test_backpressure();
      program_codes(8'hFF, 8'h00, 8'h7F, 8'h80);
      steady_sender = 1'b1;
      test_random_traffic(70);
      steady_sender = 1'b0;
      program_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      test_random_traffic(70);
      wait_drain();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
